// ===== hw/rtl/point_triangle_distance_defines.svh =====
// Assertion macros shared by the point-to-triangle distance checkers.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef POINT_TRIANGLE_DISTANCE_DEFINES_SVH
`define POINT_TRIANGLE_DISTANCE_DEFINES_SVH

// same-cycle implication, held off while in reset
`define PTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptd: assertion failed");

// next-cycle implication, held off while in reset
`define PTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptd: assertion failed");

`endif

// ===== hw/rtl/ptd_pkg.sv =====
// Shared types and constants for the point-to-triangle distance block.
// No dependencies; used by point_triangle_distance and ptd_props.
package ptd_pkg;

	localparam int COORD_BITS  = 24;
	localparam int DIST_BITS   = 25;
	localparam int REGION_BITS = 3;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	localparam logic [REGION_BITS-1:0] REGION_INTERIOR = 3'd0;
	localparam logic [REGION_BITS-1:0] REGION_EDGE12   = 3'd1;
	localparam logic [REGION_BITS-1:0] REGION_VERT2    = 3'd2;
	localparam logic [REGION_BITS-1:0] REGION_EDGE02   = 3'd3;
	localparam logic [REGION_BITS-1:0] REGION_VERT0    = 3'd4;
	localparam logic [REGION_BITS-1:0] REGION_EDGE01   = 3'd5;
	localparam logic [REGION_BITS-1:0] REGION_VERT1    = 3'd6;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
		logic signed [COORD_BITS-1:0] vert0_x;
		logic signed [COORD_BITS-1:0] vert0_y;
		logic signed [COORD_BITS-1:0] vert0_z;
		logic signed [COORD_BITS-1:0] vert1_x;
		logic signed [COORD_BITS-1:0] vert1_y;
		logic signed [COORD_BITS-1:0] vert1_z;
		logic signed [COORD_BITS-1:0] vert2_x;
		logic signed [COORD_BITS-1:0] vert2_y;
		logic signed [COORD_BITS-1:0] vert2_z;
	} query_t;

	typedef struct packed {
		logic [DIST_BITS-1:0]   distance;
		logic [REGION_BITS-1:0] region;
		logic                   degenerate;
	} result_t;

endpackage

// ===== hw/rtl/point_triangle_distance.sv =====
// Point-to-triangle distance: deep pipeline from vertex differences to the root.
// Depends on ptd_pkg for the transaction types and region codes.
//
// One transaction per clock in and out, unless query_stall holds the input. The
// pipeline runs from accept to result through the one-bit-per-stage divider
// for the barycentric parameters and the one-bit-per-stage square root. The whole
// pipeline holds while its last result cannot leave; a two-entry output stage
// (output register plus skid) keeps query_stall a registered signal. Degenerate
// triangles (zero determinant) return the distance to the first vertex with
// region 0 and degenerate set; the distance saturates at 2^25 - 1.
module point_triangle_distance #(
	parameter int PARAM_FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_stall,
	input  ptd_pkg::query_t  query,
	output logic             result_valid,
	input  logic             result_stall,
	output ptd_pkg::result_t result
);

	localparam int F    = PARAM_FRAC_BITS;
	localparam int CW   = ptd_pkg::COORD_BITS;
	localparam int RB   = ptd_pkg::REGION_BITS;
	localparam int EW   = CW + 1;          // vertex differences
	localparam int PRW  = 2 * EW;          // one dot-product term
	localparam int DW   = 2 * EW + 2;      // a, b, c, d, e
	localparam int NW   = DW + 2;          // edge sums
	localparam int H    = (DW + 1) / 2;    // low half of a split operand
	localparam int HH   = DW - H;
	localparam int PW   = 2 * DW + 1;      // det, sn, tn
	localparam int PW2  = PW + 2;
	localparam int DVW  = PW + 1;          // divider remainder
	localparam int QW   = F + 1;           // Q.F parameter, 0..1.0
	localparam int MW   = QW + 1 + EW;     // parameter times edge
	localparam int WW   = EW + F + 2;      // scaled offset component
	localparam int H2   = (WW + 1) / 2;
	localparam int HH2  = WW - H2;
	localparam int SQW  = 2 * WW;
	localparam int SW   = 2 * WW + 2;      // squared length
	localparam int RIN  = SW - 2 * F;
	localparam int XW   = RIN + (RIN % 2);
	localparam int RW   = XW / 2;          // root width
	localparam int NSTG = 15 + F + RW;

	localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};

	typedef struct packed {
		logic [2:0][EW-1:0] e0;
		logic [2:0][EW-1:0] e1;
		logic [2:0][EW-1:0] df;
	} geo_t;

	typedef struct packed {
		logic [RB-1:0] region;
		logic          deg;
	} tag_t;

	typedef struct packed {
		logic [DVW-1:0] rem;
		logic [DVW-1:0] den;
		logic [F-1:0]   q;
		logic           zero;
		logic           one;
	} lane_t;

	typedef struct packed {
		lane_t s;
		lane_t t;
		logic  s_from_t;
		logic  t_from_s;
		tag_t  tag;
		geo_t  geo;
	} div_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [RW+1:0] rem;
		logic [RW-1:0] root;
		tag_t          tag;
	} sqrt_t;

	function automatic lane_t div_step(input lane_t l);
		lane_t          r;
		logic [DVW-1:0] r2;
		r  = l;
		r2 = {l.rem[DVW-2:0], 1'b0};
		if (r2 >= l.den) begin
			r.rem = r2 - l.den;
			r.q   = {l.q[F-2:0], 1'b1};
		end else begin
			r.rem = r2;
			r.q   = {l.q[F-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_t div_stage(input div_t d);
		div_t r;
		r   = d;
		r.s = div_step(d.s);
		r.t = div_step(d.t);
		return r;
	endfunction

	function automatic sqrt_t sqrt_step(input sqrt_t d);
		sqrt_t         r;
		logic [RW+1:0] r2;
		logic [RW+1:0] trial;
		r     = d;
		r2    = {d.rem[RW-1:0], d.x[XW-1:XW-2]};
		trial = {d.root, 2'b01};
		if (r2 >= trial) begin
			r.rem  = r2 - trial;
			r.root = {d.root[RW-2:0], 1'b1};
		end else begin
			r.rem  = r2;
			r.root = {d.root[RW-2:0], 1'b0};
		end
		r.x = {d.x[XW-3:0], 2'b00};
		return r;
	endfunction

	// handshake and output stage
	logic              en;
	logic              acc;
	logic [NSTG-1:0]   stage_vld_q;
	logic              last_vld;
	logic              out_vld_q;
	logic              skid_vld_q;
	ptd_pkg::result_t  out_q;
	ptd_pkg::result_t  skid_q;
	ptd_pkg::result_t  fin;

	assign en           = !skid_vld_q;
	assign acc          = query_valid && en;
	assign query_stall  = skid_vld_q;
	assign last_vld     = stage_vld_q[NSTG-1];
	assign result_valid = out_vld_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[NSTG-2:0], acc};
		end
	end

	// stage 1: differences
	logic signed [CW-1:0] pt [3];
	logic signed [CW-1:0] v0 [3];
	logic signed [CW-1:0] v1 [3];
	logic signed [CW-1:0] v2 [3];
	geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7, geo_s8;

	assign pt[0] = query.point_x;
	assign pt[1] = query.point_y;
	assign pt[2] = query.point_z;
	assign v0[0] = query.vert0_x;
	assign v0[1] = query.vert0_y;
	assign v0[2] = query.vert0_z;
	assign v1[0] = query.vert1_x;
	assign v1[1] = query.vert1_y;
	assign v1[2] = query.vert1_z;
	assign v2[0] = query.vert2_x;
	assign v2[1] = query.vert2_y;
	assign v2[2] = query.vert2_z;

	// stage 2: dot-product terms, stage 3: dot products
	logic signed [PRW-1:0] pa_s2 [3];
	logic signed [PRW-1:0] pb_s2 [3];
	logic signed [PRW-1:0] pc_s2 [3];
	logic signed [PRW-1:0] pd_s2 [3];
	logic signed [PRW-1:0] pe_s2 [3];
	logic signed [DW-1:0]  a_s3, b_s3, c_s3, d_s3, e_s3;
	logic signed [DW-1:0]  a_s4, b_s4, c_s4, d_s4, e_s4;
	logic signed [DW-1:0]  a_s5, b_s5, c_s5, d_s5, e_s5;
	logic signed [DW-1:0]  a_s6, b_s6, c_s6, d_s6, e_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				geo_s1.e0[i] <= EW'(v1[i]) - EW'(v0[i]);
				geo_s1.e1[i] <= EW'(v2[i]) - EW'(v0[i]);
				geo_s1.df[i] <= EW'(v0[i]) - EW'(pt[i]);
				pa_s2[i] <= $signed(geo_s1.e0[i]) * $signed(geo_s1.e0[i]);
				pb_s2[i] <= $signed(geo_s1.e0[i]) * $signed(geo_s1.e1[i]);
				pc_s2[i] <= $signed(geo_s1.e1[i]) * $signed(geo_s1.e1[i]);
				pd_s2[i] <= $signed(geo_s1.e0[i]) * $signed(geo_s1.df[i]);
				pe_s2[i] <= $signed(geo_s1.e1[i]) * $signed(geo_s1.df[i]);
			end
			geo_s2 <= geo_s1;
			a_s3 <= DW'(pa_s2[0]) + DW'(pa_s2[1]) + DW'(pa_s2[2]);
			b_s3 <= DW'(pb_s2[0]) + DW'(pb_s2[1]) + DW'(pb_s2[2]);
			c_s3 <= DW'(pc_s2[0]) + DW'(pc_s2[1]) + DW'(pc_s2[2]);
			d_s3 <= DW'(pd_s2[0]) + DW'(pd_s2[1]) + DW'(pd_s2[2]);
			e_s3 <= DW'(pe_s2[0]) + DW'(pe_s2[1]) + DW'(pe_s2[2]);
			geo_s3 <= geo_s2;
		end
	end

	// stage 4: half-word partial products of ac, bb, be, cd, bd, ae
	logic signed [DW-1:0]     mx [6];
	logic signed [DW-1:0]     my [6];
	logic signed [2*HH-1:0]   pp_hh_s4 [6];
	logic signed [HH+H:0]     pp_hl_s4 [6];
	logic signed [HH+H:0]     pp_lh_s4 [6];
	logic [2*H-1:0]           pp_ll_s4 [6];
	logic signed [PW-1:0]     prod_s5 [6];
	logic signed [PW-1:0]     det_s6, sn_s6, tn_s6;

	always_comb begin
		mx[0] = a_s3; my[0] = c_s3;
		mx[1] = b_s3; my[1] = b_s3;
		mx[2] = b_s3; my[2] = e_s3;
		mx[3] = c_s3; my[3] = d_s3;
		mx[4] = b_s3; my[4] = d_s3;
		mx[5] = a_s3; my[5] = e_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				pp_hh_s4[j] <= $signed(mx[j][DW-1:H]) * $signed(my[j][DW-1:H]);
				pp_hl_s4[j] <= $signed(mx[j][DW-1:H]) * $signed({1'b0, my[j][H-1:0]});
				pp_lh_s4[j] <= $signed({1'b0, mx[j][H-1:0]}) * $signed(my[j][DW-1:H]);
				pp_ll_s4[j] <= mx[j][H-1:0] * my[j][H-1:0];
				prod_s5[j] <= (PW'(pp_hh_s4[j]) <<< (2 * H))
					+ ((PW'(pp_hl_s4[j]) + PW'(pp_lh_s4[j])) <<< H)
					+ PW'(pp_ll_s4[j]);
			end
			{a_s4, b_s4, c_s4, d_s4, e_s4} <= {a_s3, b_s3, c_s3, d_s3, e_s3};
			{a_s5, b_s5, c_s5, d_s5, e_s5} <= {a_s4, b_s4, c_s4, d_s4, e_s4};
			{a_s6, b_s6, c_s6, d_s6, e_s6} <= {a_s5, b_s5, c_s5, d_s5, e_s5};
			geo_s4 <= geo_s3;
			geo_s5 <= geo_s4;
			geo_s6 <= geo_s5;
			det_s6 <= prod_s5[0] - prod_s5[1];
			sn_s6  <= prod_s5[2] - prod_s5[3];
			tn_s6  <= prod_s5[4] - prod_s5[5];
		end
	end

	// stage 7: sign tests and edge numerators
	logic signed [PW2-1:0] st_sum;
	logic signed [DW:0]    ce_sum, ad_sum;
	logic                  deg_s7, le_s7, snn_s7, tnn_s7, dn_s7, ce_le0_s7, ad_le0_s7;
	logic signed [NW-1:0]  n_ce_s7, n_ad_s7, edg_s7, nd_s7, ne_s7;
	logic signed [DW-1:0]  a_s7, c_s7;
	logic signed [PW-1:0]  det_s7, sn_s7, tn_s7;

	assign st_sum = PW2'(sn_s6) + PW2'(tn_s6) - PW2'(det_s6);
	assign ce_sum = (DW+1)'(c_s6) + (DW+1)'(e_s6);
	assign ad_sum = (DW+1)'(a_s6) + (DW+1)'(d_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s7    <= (det_s6 == '0);
			le_s7     <= st_sum[PW2-1] || (st_sum == '0);
			snn_s7    <= sn_s6[PW-1];
			tnn_s7    <= tn_s6[PW-1];
			dn_s7     <= d_s6[DW-1];
			ce_le0_s7 <= ce_sum[DW] || (ce_sum == '0);
			ad_le0_s7 <= ad_sum[DW] || (ad_sum == '0);
			n_ce_s7   <= NW'(c_s6) + NW'(e_s6) - NW'(b_s6) - NW'(d_s6);
			n_ad_s7   <= NW'(a_s6) + NW'(d_s6) - NW'(b_s6) - NW'(e_s6);
			edg_s7    <= NW'(a_s6) - NW'(b_s6) - NW'(b_s6) + NW'(c_s6);
			nd_s7     <= -NW'(d_s6);
			ne_s7     <= -NW'(e_s6);
			a_s7      <= a_s6;
			c_s7      <= c_s6;
			det_s7    <= det_s6;
			sn_s7     <= sn_s6;
			tn_s7     <= tn_s6;
			geo_s7    <= geo_s6;
		end
	end

	// stage 8: region and divider operands
	logic                 ce_pos, ad_pos;
	logic [RB-1:0]        sel_region;
	logic signed [PW-1:0] sel_ns, sel_ds, sel_nt, sel_dt;
	logic                 sel_sft, sel_tfs;
	logic [RB-1:0]        region_s8;
	logic                 deg_s8, sft_s8, tfs_s8;
	logic signed [PW-1:0] ns_s8, ds_s8, nt_s8, dt_s8;

	assign ce_pos = !n_ce_s7[NW-1] && (n_ce_s7 != '0);
	assign ad_pos = !n_ad_s7[NW-1] && (n_ad_s7 != '0);

	// a zero numerator clamps to 0; a 1/1 quotient clamps to 1.0
	always_comb begin
		sel_region = ptd_pkg::REGION_INTERIOR;
		sel_ns     = '0;
		sel_ds     = PW'(1);
		sel_nt     = '0;
		sel_dt     = PW'(1);
		sel_sft    = 1'b0;
		sel_tfs    = 1'b0;
		if (deg_s7) begin
			sel_region = ptd_pkg::REGION_INTERIOR;
		end else if (le_s7) begin
			if (snn_s7 && tnn_s7) begin
				sel_region = ptd_pkg::REGION_VERT0;
				if (dn_s7) begin
					sel_ns = PW'(nd_s7);
					sel_ds = PW'(a_s7);
				end else begin
					sel_nt = PW'(ne_s7);
					sel_dt = PW'(c_s7);
				end
			end else if (snn_s7) begin
				sel_region = ptd_pkg::REGION_EDGE02;
				sel_nt     = PW'(ne_s7);
				sel_dt     = PW'(c_s7);
			end else if (tnn_s7) begin
				sel_region = ptd_pkg::REGION_EDGE01;
				sel_ns     = PW'(nd_s7);
				sel_ds     = PW'(a_s7);
			end else begin
				sel_region = ptd_pkg::REGION_INTERIOR;
				sel_ns     = sn_s7;
				sel_ds     = det_s7;
				sel_nt     = tn_s7;
				sel_dt     = det_s7;
			end
		end else if (snn_s7) begin
			sel_region = ptd_pkg::REGION_VERT2;
			if (ce_pos) begin
				sel_ns  = PW'(n_ce_s7);
				sel_ds  = PW'(edg_s7);
				sel_tfs = 1'b1;
			end else if (ce_le0_s7) begin
				sel_nt = PW'(1);
			end else begin
				sel_nt = PW'(ne_s7);
				sel_dt = PW'(c_s7);
			end
		end else if (tnn_s7) begin
			sel_region = ptd_pkg::REGION_VERT1;
			if (ad_pos) begin
				sel_nt  = PW'(n_ad_s7);
				sel_dt  = PW'(edg_s7);
				sel_sft = 1'b1;
			end else if (ad_le0_s7) begin
				sel_ns = PW'(1);
			end else begin
				sel_ns = PW'(nd_s7);
				sel_ds = PW'(a_s7);
			end
		end else begin
			sel_region = ptd_pkg::REGION_EDGE12;
			sel_ns     = PW'(n_ce_s7);
			sel_ds     = PW'(edg_s7);
			sel_tfs    = 1'b1;
		end
	end

	// stage 9: clamp tests, then one quotient bit per stage
	div_t div_s9;
	div_t dv_s [F];

	always_ff @(posedge clk) begin
		if (en) begin
			region_s8 <= sel_region;
			deg_s8    <= deg_s7;
			sft_s8    <= sel_sft;
			tfs_s8    <= sel_tfs;
			ns_s8     <= sel_ns;
			ds_s8     <= sel_ds;
			nt_s8     <= sel_nt;
			dt_s8     <= sel_dt;
			geo_s8    <= geo_s7;

			div_s9.s.rem      <= DVW'(ns_s8);
			div_s9.s.den      <= DVW'(ds_s8);
			div_s9.s.q        <= '0;
			div_s9.s.zero     <= ns_s8[PW-1] || (ns_s8 == '0);
			div_s9.s.one      <= (ns_s8 >= ds_s8);
			div_s9.t.rem      <= DVW'(nt_s8);
			div_s9.t.den      <= DVW'(dt_s8);
			div_s9.t.q        <= '0;
			div_s9.t.zero     <= nt_s8[PW-1] || (nt_s8 == '0);
			div_s9.t.one      <= (nt_s8 >= dt_s8);
			div_s9.s_from_t   <= sft_s8;
			div_s9.t_from_s   <= tfs_s8;
			div_s9.tag.region <= region_s8;
			div_s9.tag.deg    <= deg_s8;
			div_s9.geo        <= geo_s8;
		end
	end

	for (genvar k = 0; k < F; k++) begin : g_div
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[k] <= div_stage(div_s9);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					dv_s[k] <= div_stage(dv_s[k-1]);
				end
			end
		end
	end

	// stages after the divider are numbered on from 10
	logic [QW-1:0]        fs_raw, ft_raw;
	logic [QW-1:0]        sq_s10, tq_s10;
	tag_t                 tag_s10, tag_s11, tag_s12, tag_s13, tag_s14;
	geo_t                 geo_s10, geo_s11;
	logic signed [MW-1:0] ps_s11 [3];
	logic signed [MW-1:0] pt_s11 [3];
	logic signed [WW-1:0] w_s12 [3];
	logic signed [2*HH2-1:0] hh_s13 [3];
	logic signed [HH2+H2:0]  hl_s13 [3];
	logic [2*H2-1:0]         ll_s13 [3];
	logic signed [SQW-1:0]   sqr_s14 [3];
	logic [SW-1:0]           len_sum;
	sqrt_t                   sqi_s15;
	sqrt_t                   sqs_s [RW];

	always_comb begin
		if (dv_s[F-1].s.zero) begin
			fs_raw = '0;
		end else if (dv_s[F-1].s.one) begin
			fs_raw = ONE_Q;
		end else begin
			fs_raw = {1'b0, dv_s[F-1].s.q};
		end
		if (dv_s[F-1].t.zero) begin
			ft_raw = '0;
		end else if (dv_s[F-1].t.one) begin
			ft_raw = ONE_Q;
		end else begin
			ft_raw = {1'b0, dv_s[F-1].t.q};
		end
	end

	assign len_sum = SW'(sqr_s14[0]) + SW'(sqr_s14[1]) + SW'(sqr_s14[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s10  <= dv_s[F-1].s_from_t ? ONE_Q - ft_raw : fs_raw;
			tq_s10  <= dv_s[F-1].t_from_s ? ONE_Q - fs_raw : ft_raw;
			tag_s10 <= dv_s[F-1].tag;
			geo_s10 <= dv_s[F-1].geo;
			for (int i = 0; i < 3; i++) begin
				ps_s11[i] <= $signed({1'b0, sq_s10}) * $signed(geo_s10.e0[i]);
				pt_s11[i] <= $signed({1'b0, tq_s10}) * $signed(geo_s10.e1[i]);
				w_s12[i]  <= (WW'($signed(geo_s11.df[i])) <<< F)
					+ WW'(ps_s11[i]) + WW'(pt_s11[i]);
				hh_s13[i] <= $signed(w_s12[i][WW-1:H2]) * $signed(w_s12[i][WW-1:H2]);
				hl_s13[i] <= $signed(w_s12[i][WW-1:H2]) * $signed({1'b0, w_s12[i][H2-1:0]});
				ll_s13[i] <= w_s12[i][H2-1:0] * w_s12[i][H2-1:0];
				// cross term counted twice
				sqr_s14[i] <= (SQW'(hh_s13[i]) <<< (2 * H2))
					+ (SQW'(hl_s13[i]) <<< (H2 + 1))
					+ SQW'(ll_s13[i]);
			end
			tag_s11 <= tag_s10;
			geo_s11 <= geo_s10;
			tag_s12 <= tag_s11;
			tag_s13 <= tag_s12;
			tag_s14 <= tag_s13;
			sqi_s15.x    <= XW'(len_sum[SW-1:2*F]);
			sqi_s15.rem  <= '0;
			sqi_s15.root <= '0;
			sqi_s15.tag  <= tag_s14;
		end
	end

	// integer square root, one result bit per stage
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					sqs_s[k] <= sqrt_step(sqi_s15);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					sqs_s[k] <= sqrt_step(sqs_s[k-1]);
				end
			end
		end
	end

	always_comb begin
		fin.region     = sqs_s[RW-1].tag.region;
		fin.degenerate = sqs_s[RW-1].tag.deg;
		if (sqs_s[RW-1].root > RW'(ptd_pkg::DIST_MAX)) begin
			fin.distance = ptd_pkg::DIST_MAX;
		end else begin
			fin.distance = sqs_s[RW-1].root[ptd_pkg::DIST_BITS-1:0];
		end
	end

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !result_stall) begin
			out_vld_q  <= skid_vld_q || last_vld;
			skid_vld_q <= 1'b0;
		end else if (last_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !result_stall) begin
			out_q <= skid_vld_q ? skid_q : fin;
		end else if (last_vld && en) begin
			skid_q <= fin;
		end
	end

endmodule

// ===== hw/rtl/ptd_props.sv =====
// Port-level properties of point_triangle_distance, attached by bind below.
// Depends on ptd_pkg and point_triangle_distance_defines.svh.
`include "point_triangle_distance_defines.svh"

module ptd_props (
	input logic             clk,
	input logic             arst_n,
	input logic             query_stall,
	input logic             result_valid,
	input logic             result_stall,
	input ptd_pkg::result_t result
);

	// a stalled result holds
	`PTD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

	// input back-pressure only while a result is waiting at the output
	`PTD_ASSERT_NOW(a_stall_needs_result, query_stall, result_valid)

	// back-pressure starts only after the output was stalled
	`PTD_ASSERT_NOW(a_stall_cause, $rose(query_stall), $past(result_valid && result_stall))

	// a freed output drains the skid entry by the next cycle
	`PTD_ASSERT_NEXT(a_stall_release, query_stall && !result_stall, !query_stall)

endmodule

bind point_triangle_distance ptd_props u_ptd_props (.*);
